// ===== rtl/cc20_pkg.sv =====
// shared types, constants and round function for the chacha20 stream cipher
// no dependencies; imported by every module of the block
`default_nettype none

package cc20_pkg;

    // chunk size limit and depth of the front-to-back queue
    localparam int C_LANE_BYTES  = 8;
    localparam int C_QUEUE_DEPTH = 2;
    localparam int C_QUEUE_AW    = $clog2(C_QUEUE_DEPTH);
    localparam int C_BLOCK_BYTES = 64;

    // configuration register indexes
    localparam logic [2:0] REG_KEY_0    = 3'd0;
    localparam logic [2:0] REG_KEY_1    = 3'd1;
    localparam logic [2:0] REG_KEY_2    = 3'd2;
    localparam logic [2:0] REG_KEY_3    = 3'd3;
    localparam logic [2:0] REG_NONCE_LO = 3'd4;
    localparam logic [2:0] REG_NONCE_HI = 3'd5;
    localparam logic [2:0] REG_INIT_CTR = 3'd6;

    // "expand 32-byte k"
    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    // sixteen 32-bit words, word 0 in the low bits
    typedef logic [15:0][31:0] t_state;

    // one queued chunk after classification
    typedef struct packed {
        logic        start;
        logic [3:0]  count;
        logic [63:0] data;
    } t_item;

    // status and result of the block function unit
    typedef struct packed {
        logic   busy;
        logic   done;
        t_state block;
    } t_core_res;

    function automatic logic [31:0] rotl(logic [31:0] x, int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // one column round (diag low) or one diagonal round (diag high)
    function automatic t_state chacha_round(t_state s, logic diag);
        t_state      r;
        logic [1:0]  ln;
        logic [1:0]  lb;
        logic [1:0]  lc;
        logic [1:0]  ld;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        r = s;
        for (int j = 0; j < 4; j++) begin
            ln = 2'(j);
            lb = diag ? ln + 2'd1 : ln;
            lc = diag ? ln + 2'd2 : ln;
            ld = diag ? ln + 2'd3 : ln;
            a = s[{2'b00, ln}];
            b = s[{2'b01, lb}];
            c = s[{2'b10, lc}];
            d = s[{2'b11, ld}];
            a = a + b; d = rotl(d ^ a, 16);
            c = c + d; b = rotl(b ^ c, 12);
            a = a + b; d = rotl(d ^ a, 8);
            c = c + d; b = rotl(b ^ c, 7);
            r[{2'b00, ln}] = a;
            r[{2'b01, lb}] = b;
            r[{2'b10, lc}] = c;
            r[{2'b11, ld}] = d;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cc20_front.sv =====
// input side: takes chunks, saturates the byte count, pushes into the queue
// depends on cc20_pkg
`default_nettype none

module cc20_front
    import cc20_pkg::*;
(
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_start_req,
    input  wire logic [63:0] i_data_in,
    input  wire logic [3:0]  i_valid_bytes,
    input  wire logic        i_full,
    output logic             o_push,
    output t_item            o_item
);

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item.start = i_start_req;
        o_item.data  = i_data_in;
        // counts above the lane width are clipped
        if (i_valid_bytes > 4'(C_LANE_BYTES)) begin
            o_item.count = 4'(C_LANE_BYTES);
        end else begin
            o_item.count = i_valid_bytes;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cc20_queue.sv =====
// short fifo between the front and back parts
// depends on cc20_pkg
`default_nettype none

module cc20_queue
    import cc20_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_avail,
    output t_item      o_head
);

    t_item                  r_mem [C_QUEUE_DEPTH];
    logic [C_QUEUE_AW-1:0]  r_wr;
    logic [C_QUEUE_AW-1:0]  r_rd;
    logic [C_QUEUE_AW:0]    r_count;
    logic                   pop_ok;

    assign o_full  = (r_count == (C_QUEUE_AW+1)'(C_QUEUE_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign pop_ok  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && pop_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cc20_core.sv =====
// chacha20 block function: one round per cycle over a 16-word state register
// depends on cc20_pkg
`default_nettype none

module cc20_core
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [255:0] i_key,
    input  wire logic [95:0]  i_nonce,
    input  wire logic [31:0]  i_counter,
    output t_core_res         o_res
);

    localparam int ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int RW     = $clog2(ROUNDS);
    localparam logic [RW-1:0] LAST_ROUND = RW'(ROUNDS - 1);

    t_state          init;
    t_state          r_w;
    logic [RW-1:0]   r_round;
    logic            r_busy;
    logic            r_fin;

    always_comb begin
        init[0] = SIGMA_0;
        init[1] = SIGMA_1;
        init[2] = SIGMA_2;
        init[3] = SIGMA_3;
        for (int m = 0; m < 8; m++) begin
            init[4 + m] = i_key[32*m +: 32];
        end
        init[12] = i_counter;
        for (int m = 0; m < 3; m++) begin
            init[13 + m] = i_nonce[32*m +: 32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
            r_round <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 1'b1;
                if (r_round == LAST_ROUND) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // even rounds work on columns, odd rounds on diagonals
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_w <= init;
        end else if (r_busy) begin
            r_w <= chacha_round(r_w, r_round[0]);
        end
    end

    always_comb begin
        o_res.busy = r_busy;
        o_res.done = r_fin;
        for (int m = 0; m < 16; m++) begin
            o_res.block[m] = r_w[m] + init[m];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cc20_back.sv =====
// back part: keystream buffer, block counter, byte xor and output register
// depends on cc20_pkg; drives the cc20_core block function unit
`default_nettype none

module cc20_back
    import cc20_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_item_valid,
    input  wire t_item       i_item,
    output logic             o_pop,
    input  wire logic [31:0] i_init_ctr,
    output logic             o_core_start,
    output logic [31:0]      o_counter,
    input  wire t_core_res   i_core,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_data_out,
    output logic [3:0]       o_valid_bytes_out
);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_TAKE = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]   r_state,   n_state;
    logic [31:0]  r_counter, n_counter;
    logic [6:0]   r_avail,   n_avail;
    logic [511:0] r_ks,      n_ks;
    logic [63:0]  r_data,    n_data;
    logic [3:0]   r_cnt,     n_cnt;
    logic [3:0]   r_rem,     n_rem;
    logic [3:0]   r_off,     n_off;
    logic [63:0]  r_res,     n_res;
    logic         r_out_valid;
    logic [63:0]  r_out_data;
    logic [3:0]   r_out_vb;

    logic [3:0]   take_n;
    logic [3:0]   take_end;
    logic [3:0]   rem_left;
    logic [63:0]  take_res;
    logic [63:0]  ks_low;
    logic         out_free;
    logic         out_wr;
    logic [63:0]  out_res;

    assign ks_low   = r_ks[63:0];
    assign out_free = !r_out_valid || !i_stall;

    // bytes taken this cycle: the smaller of what is left and what is buffered
    always_comb begin : p_take
        logic [3:0] bi;
        logic [3:0] sel;
        if ({3'b000, r_rem} < r_avail) begin
            take_n = r_rem;
        end else begin
            take_n = r_avail[3:0];
        end
        take_end = r_off + take_n;
        rem_left = r_rem - take_n;
        take_res = r_res;
        for (int i = 0; i < 8; i++) begin
            bi  = 4'(i);
            sel = bi - r_off;
            if (bi >= r_off && bi < take_end) begin
                take_res[8*i +: 8] = r_data[8*i +: 8] ^ ks_low[{sel[2:0], 3'b000} +: 8];
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_counter    = r_counter;
        n_avail      = r_avail;
        n_ks         = r_ks;
        n_data       = r_data;
        n_cnt        = r_cnt;
        n_rem        = r_rem;
        n_off        = r_off;
        n_res        = r_res;
        o_pop        = 1'b0;
        o_core_start = 1'b0;
        out_wr       = 1'b0;
        out_res      = r_res;
        case (r_state)
            ST_LOAD: begin
                if (i_item_valid) begin
                    o_pop   = 1'b1;
                    n_data  = i_item.data;
                    n_cnt   = i_item.count;
                    n_rem   = i_item.count;
                    n_off   = '0;
                    n_res   = '0;
                    if (i_item.start) begin
                        n_counter = i_init_ctr;
                        n_avail   = '0;
                    end
                    n_state = ST_TAKE;
                end
            end
            ST_TAKE: begin
                if (r_rem != '0 && r_avail == '0) begin
                    o_core_start = 1'b1;
                    n_state      = ST_CALC;
                end else begin
                    n_ks    = r_ks >> {take_n, 3'b000};
                    n_avail = r_avail - {3'b000, take_n};
                    n_rem   = rem_left;
                    n_off   = take_end;
                    n_res   = take_res;
                    if (rem_left == '0) begin
                        if (out_free) begin
                            out_wr  = 1'b1;
                            out_res = take_res;
                            n_state = ST_LOAD;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                end
            end
            ST_CALC: begin
                if (i_core.done) begin
                    n_ks      = i_core.block;
                    n_avail   = 7'(C_BLOCK_BYTES);
                    n_counter = r_counter + 32'd1;
                    n_state   = ST_TAKE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_wr  = 1'b1;
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_counter   <= '0;
            r_avail     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_counter <= n_counter;
            r_avail   <= n_avail;
            if (out_wr) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ks   <= n_ks;
        r_data <= n_data;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_off  <= n_off;
        r_res  <= n_res;
        if (out_wr) begin
            r_out_data <= out_res;
            r_out_vb   <= r_cnt;
        end
    end

    assign o_counter         = r_counter;
    assign o_valid           = r_out_valid;
    assign o_data_out        = r_out_data;
    assign o_valid_bytes_out = r_out_vb;

endmodule

`default_nettype wire

// ===== rtl/chacha20_stream_cipher.sv =====
// chacha20 stream cipher, chunks of up to eight bytes per transfer
// a chunk passes through the queue, the load and take states and the output register
// a new 64-byte block is computed when the buffer runs dry, also midway through a chunk
// chunks are handled one at a time while the queue buffers more; one block per 64 bytes
// synchronous active-low reset: counter 0, no keystream buffered, configuration registers 0
`default_nettype none

module chacha20_stream_cipher
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input chunk channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_start_req,
    input  wire logic [63:0] i_data_in,
    input  wire logic [3:0]  i_valid_bytes,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_data_out,
    output logic [3:0]       o_valid_bytes_out,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    // configuration registers
    logic [63:0] r_key_0;
    logic [63:0] r_key_1;
    logic [63:0] r_key_2;
    logic [63:0] r_key_3;
    logic [63:0] r_nonce_lo;
    logic [31:0] r_nonce_hi;
    logic [31:0] r_init_ctr;

    // front to queue
    logic        push;
    t_item       push_item;
    logic        q_full;
    // queue to back
    logic        q_avail;
    t_item       q_head;
    logic        pop;
    // back to block function unit
    logic        core_start;
    logic [31:0] counter;
    t_core_res   core_res;

    // writes are always taken; an unknown index is dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_0    <= '0;
            r_key_1    <= '0;
            r_key_2    <= '0;
            r_key_3    <= '0;
            r_nonce_lo <= '0;
            r_nonce_hi <= '0;
            r_init_ctr <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_KEY_0:    r_key_0    <= i_cfg_data;
                REG_KEY_1:    r_key_1    <= i_cfg_data;
                REG_KEY_2:    r_key_2    <= i_cfg_data;
                REG_KEY_3:    r_key_3    <= i_cfg_data;
                REG_NONCE_LO: r_nonce_lo <= i_cfg_data;
                REG_NONCE_HI: r_nonce_hi <= i_cfg_data[31:0];
                REG_INIT_CTR: r_init_ctr <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // front: classify the chunk and push it on transfer
    cc20_front u_front (
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_start_req   (i_start_req),
        .i_data_in     (i_data_in),
        .i_valid_bytes (i_valid_bytes),
        .i_full        (q_full),
        .o_push        (push),
        .o_item        (push_item)
    );

    // decouples input transfers from block computation
    cc20_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_avail (q_avail),
        .o_head  (q_head)
    );

    // keystream block generator, key/nonce words in little-endian order
    cc20_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (core_start),
        .i_key     ({r_key_3, r_key_2, r_key_1, r_key_0}),
        .i_nonce   ({r_nonce_hi, r_nonce_lo}),
        .i_counter (counter),
        .o_res     (core_res)
    );

    // back: consumes buffered keystream, requests blocks on demand,
    // holds the result register so the queue keeps filling under stall
    cc20_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item_valid      (q_avail),
        .i_item            (q_head),
        .o_pop             (pop),
        .i_init_ctr        (r_init_ctr),
        .o_core_start      (core_start),
        .o_counter         (counter),
        .i_core            (core_res),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_data_out        (o_data_out),
        .o_valid_bytes_out (o_valid_bytes_out)
    );

    // a block is never requested while one is being computed
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_start |-> !core_res.busy && !core_res.done)
        else $error("block requested while block unit active");

    // a request starts the round sequence on the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_start |=> core_res.busy)
        else $error("block unit did not start");

    // a finished block always follows the last round
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_res.done |-> $past(core_res.busy))
        else $error("block done without rounds");

    // the queue is never popped while empty
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_avail)
        else $error("queue popped while empty");

endmodule

`default_nettype wire
